FILE: rtl/rwsb_pkg.sv
package rwsb_pkg;

    localparam int FRAC_BITS = 24;

    // port field widths
    localparam int CS_W  = 25;
    localparam int VEL_W = 32;
    localparam int LOR_W = 31;
    localparam int MAX_W = 31;
    localparam int MIN_W = 32;

    // internal datapath widths
    localparam int N_W      = 42;
    localparam int PR_W     = N_W + CS_W + 2;
    localparam int TR_W     = 72;
    localparam int ROOT_W   = 33;
    localparam int RAD_W    = 67;
    localparam int DIV_BITS = 32;
    localparam int Q_W      = DIV_BITS + 2;

    localparam logic signed [N_W-1:0]  ONE_N  = N_W'(64'd1 << FRAC_BITS);
    localparam logic signed [CS_W:0]   ONE_CS = (CS_W+1)'(64'd1 << FRAC_BITS);
    localparam logic signed [Q_W-1:0]  Q_ONE  = Q_W'(64'd1 << FRAC_BITS);
    localparam logic signed [Q_W-1:0]  Q_CLIP = Q_W'(64'd1 << DIV_BITS);
    localparam logic signed [Q_W-1:0]  Q_MAX_LIM = Q_W'((64'd1 << MAX_W) - 64'd1);
    localparam logic signed [Q_W-1:0]  Q_MIN_LIM = -Q_W'(64'd1 << (MIN_W - 1));

    localparam logic [MAX_W-1:0] BOUND_MAX =
        MAX_W'((64'd101 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic signed [MIN_W-1:0] BOUND_MIN = MIN_W'(-$signed({1'b0, BOUND_MAX}));

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_SUPERLUMINAL = 2'd1,
        ST_NEG_DISC     = 2'd2
    } t_status;

    typedef struct packed {
        logic en;
        logic valid;
    } t_ctl;

    // drop the fraction bits of a product, rounding toward zero
    function automatic logic signed [TR_W-1:0] trunc_frac(input logic signed [TR_W-1:0] p);
        logic signed [TR_W-1:0] s;
        logic                   adj;
        s   = p >>> FRAC_BITS;
        adj = p[TR_W-1] && (p[FRAC_BITS-1:0] != '0);
        return s + TR_W'(adj);
    endfunction

endpackage

FILE: rtl/rwsb_sqrt.sv
module rwsb_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rwsb_pkg::t_ctl              i_ctl,
    input  logic [rwsb_pkg::RAD_W-1:0]  i_rad,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [rwsb_pkg::ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0]           o_side
);
    import rwsb_pkg::*;

    logic [ROOT_W:0]     r_valid;
    logic [RAD_W-1:0]    r_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]   r_root [0:ROOT_W];
    logic [SIDE_W-1:0]   r_side [0:ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.en) begin
            r_valid <= {r_valid[ROOT_W-1:0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rem[0]  <= i_rad;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    // one root bit per stage, remainder kept as rad - root^2
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int SH = ROOT_W - 1 - k;
        logic [RAD_W-1:0] trial;
        logic             fits;

        assign trial = (RAD_W'(r_root[k]) << (SH + 1)) + (RAD_W'(1) << (2 * SH));
        assign fits  = r_rem[k] >= trial;

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[k+1]  <= fits ? r_rem[k] - trial : r_rem[k];
                r_root[k+1] <= r_root[k] | (fits ? (ROOT_W'(1) << SH) : '0);
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_valid[ROOT_W];
    assign o_root  = r_root[ROOT_W];
    assign o_side  = r_side[ROOT_W];

endmodule

FILE: rtl/rwsb_state.sv
module rwsb_state (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rwsb_pkg::t_ctl                    i_ctl,
    input  logic [rwsb_pkg::CS_W-1:0]         i_cs,
    input  logic signed [rwsb_pkg::VEL_W-1:0] i_vel,
    input  logic [rwsb_pkg::LOR_W-1:0]        i_lor,
    output logic                              o_valid,
    output logic signed [rwsb_pkg::N_W-1:0]   o_np,
    output logic signed [rwsb_pkg::N_W-1:0]   o_nm,
    output logic signed [rwsb_pkg::N_W-1:0]   o_den,
    output logic                              o_bad
);
    import rwsb_pkg::*;

    localparam int GG_W   = 2 * LOR_W - FRAC_BITS;
    localparam int UU_W   = 2 * VEL_W - 1 - FRAC_BITS;
    localparam int SIDE_W = 2 * N_W + 1;

    logic [6:0] r_valid;

    logic [CS_W-1:0]            r1_cs;
    logic signed [CS_W:0]       r1_omc;
    logic [2*LOR_W-1:0]         r1_pgg;
    logic signed [2*VEL_W-1:0]  r1_pgu;
    logic signed [2*VEL_W-1:0]  r1_puu;

    logic [CS_W-1:0]            r2_cs;
    logic signed [CS_W:0]       r2_omc;
    logic [GG_W-1:0]            r2_gg;
    logic signed [N_W-1:0]      r2_gu, r2_uu, r2_uum1;

    logic [CS_W-1:0]            r3_cs;
    logic signed [N_W-1:0]      r3_uu;
    logic signed [PR_W-1:0]     r3_pa, r3_pggo, r3_pt;

    logic [CS_W-1:0]            r4_cs;
    logic signed [N_W-1:0]      r4_uu, r4_a, r4_d, r4_t;

    logic [CS_W-1:0]            r5_cs;
    logic signed [N_W:0]        r5_w;
    logic signed [N_W-1:0]      r5_a, r5_d;

    logic signed [PR_W-1:0]     r6_pb;
    logic signed [N_W-1:0]      r6_a, r6_d;

    logic signed [N_W+1:0]      r7_b;
    logic signed [N_W-1:0]      r7_a, r7_d;

    logic [GG_W-1:0]            gg1;
    logic [UU_W-1:0]            uu2;
    logic                       bad;
    logic [RAD_W-1:0]           rad;
    t_ctl                       sq_ctl;
    logic                       sq_valid;
    logic [ROOT_W-1:0]          sq_root;
    logic [SIDE_W-1:0]          sq_side;

    logic                       r_num_valid;
    logic signed [N_W-1:0]      r_np, r_nm, r_den;
    logic                       r_bad;

    assign gg1 = r1_pgg[2*LOR_W-1:FRAC_BITS];
    assign uu2 = UU_W'(r1_puu >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_num_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid     <= {r_valid[5:0], i_ctl.valid};
            r_num_valid <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r1_cs   <= i_cs;
            r1_omc  <= ONE_CS - $signed({1'b0, i_cs});
            r1_pgg  <= i_lor * i_lor;
            r1_pgu  <= $signed({1'b0, i_lor}) * i_vel;
            r1_puu  <= i_vel * i_vel;

            r2_cs   <= r1_cs;
            r2_omc  <= r1_omc;
            r2_gg   <= gg1;
            r2_gu   <= N_W'(trunc_frac(TR_W'(r1_pgu)));
            r2_uu   <= $signed(N_W'(gg1)) - $signed(N_W'(uu2));
            r2_uum1 <= $signed(N_W'(gg1)) - $signed(N_W'(uu2)) - ONE_N;

            r3_cs   <= r2_cs;
            r3_uu   <= r2_uu;
            r3_pa   <= r2_gu * r2_omc;
            r3_pggo <= $signed({1'b0, r2_gg}) * r2_omc;
            r3_pt   <= r2_uum1 * $signed({1'b0, r2_cs});

            r4_cs   <= r3_cs;
            r4_uu   <= r3_uu;
            r4_a    <= N_W'(trunc_frac(TR_W'(r3_pa)));
            r4_d    <= N_W'(trunc_frac(TR_W'(r3_pggo))) + $signed(N_W'(r3_cs));
            r4_t    <= N_W'(trunc_frac(TR_W'(r3_pt)));

            r5_cs   <= r4_cs;
            r5_w    <= (N_W+1)'(r4_uu) - (N_W+1)'(r4_t);
            r5_a    <= r4_a;
            r5_d    <= r4_d;

            r6_pb   <= r5_w * $signed({1'b0, r5_cs});
            r6_a    <= r5_a;
            r6_d    <= r5_d;

            r7_b    <= (N_W+2)'(trunc_frac(TR_W'(r6_pb)));
            r7_a    <= r6_a;
            r7_d    <= r6_d;

            r_np    <= sq_side[SIDE_W-1 -: N_W] + $signed(N_W'(sq_root));
            r_nm    <= sq_side[SIDE_W-1 -: N_W] - $signed(N_W'(sq_root));
            r_den   <= sq_side[N_W:1];
            r_bad   <= sq_side[0];
        end
    end

    // negative discriminant takes a zero root
    assign bad = r7_b[N_W+1];
    assign rad = bad ? '0 : RAD_W'({r7_b[N_W-1:0], {FRAC_BITS{1'b0}}});

    assign sq_ctl.en    = i_ctl.en;
    assign sq_ctl.valid = r_valid[6];

    rwsb_sqrt #(
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sq_ctl),
        .i_rad   (rad),
        .i_side  ({r7_a, r7_d, bad}),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign o_valid = r_num_valid;
    assign o_np    = r_np;
    assign o_nm    = r_nm;
    assign o_den   = r_den;
    assign o_bad   = r_bad;

endmodule

FILE: rtl/rwsb_div.sv
module rwsb_div #(
    parameter int SIDE_W = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rwsb_pkg::t_ctl                  i_ctl,
    input  logic signed [rwsb_pkg::N_W-1:0] i_num,
    input  logic signed [rwsb_pkg::N_W-1:0] i_den,
    input  logic [SIDE_W-1:0]               i_side,
    output logic                            o_valid,
    output logic signed [rwsb_pkg::Q_W-1:0] o_quo,
    output logic [SIDE_W-1:0]               o_side
);
    import rwsb_pkg::*;

    localparam int HI_SH = DIV_BITS - FRAC_BITS;

    logic [DIV_BITS+1:0]   r_valid;
    logic                  r_neg  [0:DIV_BITS];
    logic                  r_zero [0:DIV_BITS];
    logic                  r_ovf  [0:DIV_BITS];
    logic [N_W-1:0]        r_ud   [0:DIV_BITS];
    logic [N_W:0]          r_rem  [0:DIV_BITS];
    logic [DIV_BITS-1:0]   r_low  [0:DIV_BITS];
    logic [DIV_BITS-1:0]   r_q    [0:DIV_BITS];
    logic [SIDE_W-1:0]     r_side [0:DIV_BITS];

    logic signed [Q_W-1:0] r_quo;
    logic [SIDE_W-1:0]     r_side_out;

    logic [N_W-1:0]        un, ud;

    assign un = i_num[N_W-1] ? N_W'(-i_num) : N_W'(i_num);
    assign ud = i_den[N_W-1] ? N_W'(-i_den) : N_W'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.en) begin
            r_valid <= {r_valid[DIV_BITS:0], i_ctl.valid};
        end
    end

    // quotient fits DIV_BITS bits unless un >= ud * 2^HI_SH (also zero divisor)
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_neg[0]  <= i_num[N_W-1] ^ i_den[N_W-1];
            r_zero[0] <= (un == '0);
            r_ovf[0]  <= ({{HI_SH{1'b0}}, un} >= {ud, {HI_SH{1'b0}}});
            r_ud[0]   <= ud;
            r_rem[0]  <= (N_W+1)'(un >> HI_SH);
            r_low[0]  <= {un[HI_SH-1:0], {FRAC_BITS{1'b0}}};
            r_q[0]    <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
        logic [N_W+1:0] rs;
        logic           ge;

        assign rs = {r_rem[k], r_low[k][DIV_BITS-1]};
        assign ge = rs >= (N_W+2)'(r_ud[k]);

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[k+1]  <= (N_W+1)'(ge ? rs - (N_W+2)'(r_ud[k]) : rs);
                r_q[k+1]    <= {r_q[k][DIV_BITS-2:0], ge};
                r_low[k+1]  <= r_low[k] << 1;
                r_neg[k+1]  <= r_neg[k];
                r_zero[k+1] <= r_zero[k];
                r_ovf[k+1]  <= r_ovf[k];
                r_ud[k+1]   <= r_ud[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            priority if (r_zero[DIV_BITS]) begin
                r_quo <= '0;
            end else if (r_ovf[DIV_BITS]) begin
                r_quo <= r_neg[DIV_BITS] ? -Q_CLIP : Q_CLIP;
            end else begin
                r_quo <= r_neg[DIV_BITS] ? -$signed(Q_W'(r_q[DIV_BITS]))
                                         : $signed(Q_W'(r_q[DIV_BITS]));
            end
            r_side_out <= r_side[DIV_BITS];
        end
    end

    assign o_valid = r_valid[DIV_BITS+1];
    assign o_quo   = r_quo;
    assign o_side  = r_side_out;

endmodule

FILE: rtl/relativistic_wave_speed_bounds.sv
// Wave speed bounds for one cell face of a relativistic fluid solver.
// Input channel: i_in_valid / o_in_stall carries a left and a right state
// (sound speed squared, velocity, Lorentz factor, 24 fraction bits).
// Output channel: o_out_valid / i_out_stall carries speed_max, speed_min and
// status (0 ok, 1 a speed magnitude above one, 2 negative discriminant).
// A request moves when valid is high and stall is low.
// Throughput is one request per cycle while o_in_stall is low. On its way
// to o_out_valid a request passes 7 multiply stages, 34 square root stages,
// a numerator stage, 34 divider stages (input, one per quotient bit,
// output), a merge stage and the output reg, 78 registers in all.
// i_cfg_we / i_cfg_wdata set the light speed mode, which answers +-1.01 and
// status 0; write it only while no request is in flight.
// When the receiver stalls, the output register holds and a skid register
// takes one more result; with the skid full the pipeline freezes and
// o_in_stall is raised, so nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and clears the mode.
module relativistic_wave_speed_bounds (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [rwsb_pkg::CS_W-1:0]         i_sound_speed_sq_left,
    input  logic signed [rwsb_pkg::VEL_W-1:0] i_velocity_left,
    input  logic [rwsb_pkg::LOR_W-1:0]        i_lorentz_left,
    input  logic [rwsb_pkg::CS_W-1:0]         i_sound_speed_sq_right,
    input  logic signed [rwsb_pkg::VEL_W-1:0] i_velocity_right,
    input  logic [rwsb_pkg::LOR_W-1:0]        i_lorentz_right,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rwsb_pkg::MAX_W-1:0]        o_speed_max,
    output logic signed [rwsb_pkg::MIN_W-1:0] o_speed_min,
    output logic [1:0]                        o_status
);
    import rwsb_pkg::*;

    logic                  r_mode;
    logic                  en;
    t_ctl                  in_ctl, l_ctl, r_ctl;

    logic                  l_valid, rt_valid;
    logic signed [N_W-1:0] l_np, l_nm, l_den, rt_np, rt_nm, rt_den;
    logic                  l_bad, rt_bad;

    logic                  lp_valid, lm_valid, rp_valid, rm_valid;
    logic signed [Q_W-1:0] lp_q, lm_q, rp_q, rm_q;
    logic                  lp_bad, lm_bad, rp_bad, rm_bad;

    logic signed [Q_W-1:0] mx, mn, ap_c, am_c;
    logic                  r_m_valid, r_m_bad;
    logic signed [Q_W-1:0] r_m_ap, r_m_am;

    logic [MAX_W-1:0]        fin_max;
    logic signed [MIN_W-1:0] fin_min;
    t_status                 fin_st;

    logic                    r_out_valid, r_skid_valid;
    logic                    n_out_valid, n_skid_valid;
    logic                    push, take, load_out, load_skid;
    logic [MAX_W-1:0]        r_out_max, r_skid_max;
    logic signed [MIN_W-1:0] r_out_min, r_skid_min;
    t_status                 r_out_st, r_skid_st;

    // the whole pipeline advances while the skid register is empty
    assign en           = !r_skid_valid;
    assign in_ctl.en    = en;
    assign in_ctl.valid = i_in_valid;
    assign l_ctl.en     = en;
    assign l_ctl.valid  = l_valid;
    assign r_ctl.en     = en;
    assign r_ctl.valid  = rt_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    rwsb_state u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (in_ctl),
        .i_cs    (i_sound_speed_sq_left),
        .i_vel   (i_velocity_left),
        .i_lor   (i_lorentz_left),
        .o_valid (l_valid),
        .o_np    (l_np),
        .o_nm    (l_nm),
        .o_den   (l_den),
        .o_bad   (l_bad)
    );

    rwsb_state u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (in_ctl),
        .i_cs    (i_sound_speed_sq_right),
        .i_vel   (i_velocity_right),
        .i_lor   (i_lorentz_right),
        .o_valid (rt_valid),
        .o_np    (rt_np),
        .o_nm    (rt_nm),
        .o_den   (rt_den),
        .o_bad   (rt_bad)
    );

    rwsb_div #(.SIDE_W(1)) u_div_lp (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (l_ctl),
        .i_num (l_np), .i_den (l_den), .i_side (l_bad),
        .o_valid (lp_valid), .o_quo (lp_q), .o_side (lp_bad)
    );

    rwsb_div #(.SIDE_W(1)) u_div_lm (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (l_ctl),
        .i_num (l_nm), .i_den (l_den), .i_side (l_bad),
        .o_valid (lm_valid), .o_quo (lm_q), .o_side (lm_bad)
    );

    rwsb_div #(.SIDE_W(1)) u_div_rp (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (r_ctl),
        .i_num (rt_np), .i_den (rt_den), .i_side (rt_bad),
        .o_valid (rp_valid), .o_quo (rp_q), .o_side (rp_bad)
    );

    rwsb_div #(.SIDE_W(1)) u_div_rm (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (r_ctl),
        .i_num (rt_nm), .i_den (rt_den), .i_side (rt_bad),
        .o_valid (rm_valid), .o_quo (rm_q), .o_side (rm_bad)
    );

    always_comb begin
        mx   = (lp_q > rp_q) ? lp_q : rp_q;
        mn   = (lm_q < rm_q) ? lm_q : rm_q;
        ap_c = mx[Q_W-1] ? '0 : mx;
        am_c = (mn > 0) ? '0 : mn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= lp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_ap  <= ap_c;
            r_m_am  <= am_c;
            r_m_bad <= lp_bad | rp_bad;
        end
    end

    // status is judged before the output saturation
    always_comb begin
        if (r_mode) begin
            fin_max = BOUND_MAX;
            fin_min = BOUND_MIN;
            fin_st  = ST_OK;
        end else begin
            fin_max = (r_m_ap > Q_MAX_LIM) ? '1 : r_m_ap[MAX_W-1:0];
            fin_min = (r_m_am < Q_MIN_LIM) ? {1'b1, {(MIN_W-1){1'b0}}}
                                           : r_m_am[MIN_W-1:0];
            priority if (r_m_bad) begin
                fin_st = ST_NEG_DISC;
            end else if (r_m_ap > Q_ONE || r_m_am < -Q_ONE) begin
                fin_st = ST_SUPERLUMINAL;
            end else begin
                fin_st = ST_OK;
            end
        end
    end

    assign push      = en && r_m_valid;
    assign take      = r_out_valid && !i_out_stall;
    assign load_out  = push && (!r_out_valid || take);
    assign load_skid = push && r_out_valid && !take;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (push) begin
            if (load_out) begin
                n_out_valid = 1'b1;
            end else begin
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            if (r_skid_valid) begin
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_max <= fin_max;
            r_out_min <= fin_min;
            r_out_st  <= fin_st;
        end else if (take && r_skid_valid) begin
            r_out_max <= r_skid_max;
            r_out_min <= r_skid_min;
            r_out_st  <= r_skid_st;
        end
        if (load_skid) begin
            r_skid_max <= fin_max;
            r_skid_min <= fin_min;
            r_skid_st  <= fin_st;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_speed_max = r_out_max;
    assign o_speed_min = r_out_min;
    assign o_status    = r_out_st;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_div_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lp_valid |-> (lm_valid && rp_valid && rm_valid))
        else $error("divider lanes out of step");

    a_bad_flags_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lp_valid && lm_valid) |-> (lp_bad == lm_bad && rp_bad == rm_bad))
        else $error("discriminant flag split between lanes");

    a_skid_fills_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && push) |=> r_skid_valid)
        else $error("result dropped while receiver stalled");

    a_min_not_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_min[MIN_W-1] || r_out_min == '0))
        else $error("speed_min above zero");

endmodule

FILE: tb/tb_checker.sv
module tb_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_wdata,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [rwsb_pkg::CS_W-1:0]         cs_l,
    input  logic signed [rwsb_pkg::VEL_W-1:0] vel_l,
    input  logic [rwsb_pkg::LOR_W-1:0]        lor_l,
    input  logic [rwsb_pkg::CS_W-1:0]         cs_r,
    input  logic signed [rwsb_pkg::VEL_W-1:0] vel_r,
    input  logic [rwsb_pkg::LOR_W-1:0]        lor_r,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [rwsb_pkg::MAX_W-1:0]        speed_max,
    input  logic signed [rwsb_pkg::MIN_W-1:0] speed_min,
    input  logic [1:0]                        status,
    output int                                pending,
    output int                                errors
);
    import rwsb_pkg::*;

    localparam longint LIM = 64'sd4611686018427387903;
    localparam longint UNIT = 64'sd1 << FRAC_BITS;

    typedef struct {
        logic [MAX_W-1:0]        smax;
        logic signed [MIN_W-1:0] smin;
        t_status                 st;
    } t_bounds;

    t_bounds bounds_q[$];
    logic    light_mode;

    function automatic longint sat(longint v);
        if (v > LIM) return LIM;
        if (v < -LIM) return -LIM;
        return v;
    endfunction

    function automatic logic [63:0] mag(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] p;
        longint       v;
        p = {64'd0, mag(a)} * {64'd0, mag(b)};
        p = p >> FRAC_BITS;
        v = (p > 128'(LIM)) ? LIM : longint'(p[63:0]);
        return ((a < 0) != (b < 0)) ? -v : v;
    endfunction

    function automatic longint fx_div(longint n, longint d);
        logic [63:0] un, ud, q, r;
        un = mag(n);
        ud = mag(d);
        if (d == 0) return n > 0 ? LIM : (n < 0 ? -LIM : 0);
        q = un / ud;
        r = un % ud;
        for (int i = 0; i < FRAC_BITS; i++) begin
            if (q > (64'(LIM) >> 1)) begin
                q = 64'(LIM);
                break;
            end
            r = r << 1;
            q = q << 1;
            if (r >= ud) begin
                r = r - ud;
                q = q | 64'd1;
            end
        end
        if (q > 64'(LIM)) q = 64'(LIM);
        return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint fx_sqrt(longint b);
        logic [127:0] x;
        logic [63:0]  res, c;
        x = {64'd0, 64'(b)} << FRAC_BITS;
        res = 0;
        for (int bit_i = 47; bit_i >= 0; bit_i--) begin
            c = res | (64'd1 << bit_i);
            if ({64'd0, c} * {64'd0, c} <= x) res = c;
        end
        return longint'(res);
    endfunction

    // characteristic speeds of one fluid state, returns 1 on negative discriminant
    function automatic logic state_speeds(logic [CS_W-1:0] cs_in, logic signed [VEL_W-1:0] u_in,
                                          logic [LOR_W-1:0] g_in, output longint sp,
                                          output longint sm);
        longint cs, u, g, omc, gg, a, uu, b, d, s;
        cs  = longint'({39'd0, cs_in});
        u   = longint'(u_in);
        g   = longint'({33'd0, g_in});
        omc = UNIT - cs;
        gg  = fx_mul(g, g);
        a   = fx_mul(fx_mul(g, u), omc);
        uu  = sat(gg - fx_mul(u, u));
        b   = fx_mul(sat(uu - fx_mul(sat(uu - UNIT), cs)), cs);
        d   = sat(fx_mul(gg, omc) + cs);
        s   = (b < 0) ? 0 : fx_sqrt(b);
        sp  = fx_div(sat(a + s), d);
        sm  = fx_div(sat(a - s), d);
        return b < 0;
    endfunction

    function automatic t_bounds face_bounds();
        t_bounds r;
        longint  pl, ml, pr, mr, hi, lo;
        logic    bad_l, bad_r;
        if (light_mode) begin
            r.smax = BOUND_MAX;
            r.smin = BOUND_MIN;
            r.st   = ST_OK;
            return r;
        end
        bad_l = state_speeds(cs_l, vel_l, lor_l, pl, ml);
        bad_r = state_speeds(cs_r, vel_r, lor_r, pr, mr);
        hi = (pl > pr) ? pl : pr;
        if (hi < 0) hi = 0;
        lo = (ml < mr) ? ml : mr;
        if (lo > 0) lo = 0;
        if (bad_l || bad_r) r.st = ST_NEG_DISC;
        else if (hi > UNIT || lo < -UNIT) r.st = ST_SUPERLUMINAL;
        else r.st = ST_OK;
        if (hi > 64'sh7FFFFFFF) hi = 64'sh7FFFFFFF;
        if (lo < -(64'sd1 << 31)) lo = -(64'sd1 << 31);
        r.smax = hi[MAX_W-1:0];
        r.smin = lo[MIN_W-1:0];
        return r;
    endfunction

    always @(posedge clk) begin
        t_bounds e;
        if (!rst_n) begin
            light_mode <= 1'b0;
            errors = 0;
        end else begin
            if (in_valid && !in_stall) bounds_q.push_back(face_bounds());
            if (out_valid && !out_stall) begin
                if (bounds_q.size() == 0) begin
                    $display("%0t: unexpected result max=%h min=%h status=%0d",
                             $time, speed_max, speed_min, status);
                    errors++;
                end else begin
                    e = bounds_q.pop_front();
                    if (speed_max !== e.smax) begin
                        $display("%0t: speed_max expected %h actual %h", $time, e.smax, speed_max);
                        errors++;
                    end
                    if (speed_min !== e.smin) begin
                        $display("%0t: speed_min expected %h actual %h", $time, e.smin, speed_min);
                        errors++;
                    end
                    if (status !== e.st) begin
                        $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                        errors++;
                    end
                end
            end
            if (cfg_we) light_mode <= cfg_wdata;
        end
        pending = bounds_q.size();
    end

endmodule

FILE: tb/tb_top.sv
module tb_top;
    import rwsb_pkg::*;

    localparam int UNIT = 1 << FRAC_BITS;
    localparam int DRAIN_CYCLES = 100;
    localparam int IDLE_LIMIT = 20000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic                     i_cfg_wdata = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [CS_W-1:0]          cs_l = '0;
    logic signed [VEL_W-1:0]  vel_l = '0;
    logic [LOR_W-1:0]         lor_l = LOR_W'(UNIT);
    logic [CS_W-1:0]          cs_r = '0;
    logic signed [VEL_W-1:0]  vel_r = '0;
    logic [LOR_W-1:0]         lor_r = LOR_W'(UNIT);
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [MAX_W-1:0]         o_speed_max;
    logic signed [MIN_W-1:0]  o_speed_min;
    logic [1:0]               o_status;
    int                       pending;
    int                       errors;
    logic                     quiet = 1'b0;
    int                       idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    relativistic_wave_speed_bounds u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_sound_speed_sq_left(cs_l), .i_velocity_left(vel_l), .i_lorentz_left(lor_l),
        .i_sound_speed_sq_right(cs_r), .i_velocity_right(vel_r), .i_lorentz_right(lor_r),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_speed_max(o_speed_max), .o_speed_min(o_speed_min), .o_status(o_status)
    );

    tb_checker u_checker (
        .clk(i_clk), .rst_n(i_rst_n), .cfg_we(i_cfg_we), .cfg_wdata(i_cfg_wdata),
        .in_valid(i_in_valid), .in_stall(o_in_stall),
        .cs_l(cs_l), .vel_l(vel_l), .lor_l(lor_l),
        .cs_r(cs_r), .vel_r(vel_r), .lor_r(lor_r),
        .out_valid(o_out_valid), .out_stall(i_out_stall),
        .speed_max(o_speed_max), .speed_min(o_speed_min), .status(o_status),
        .pending(pending), .errors(errors)
    );

    // receiver stalls in short bursts
    always @(posedge i_clk) begin
        int n;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 4);
            i_out_stall <= 1'b1;
            repeat (n) @(posedge i_clk);
        end
        i_out_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("relativistic_wave_speed_bounds verification failed");
            $finish;
        end
    end

    task automatic send_face(logic [CS_W-1:0] csl, logic signed [VEL_W-1:0] vl,
                             logic [LOR_W-1:0] gl, logic [CS_W-1:0] csr,
                             logic signed [VEL_W-1:0] vr, logic [LOR_W-1:0] gr);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        cs_l <= csl;  vel_l <= vl;  lor_l <= gl;
        cs_r <= csr;  vel_r <= vr;  lor_r <= gr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(logic v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [LOR_W-1:0] rand_lorentz();
        if ($urandom_range(0, 3) == 0) return LOR_W'($urandom_range(UNIT, 32'h7FFFFFFF));
        return LOR_W'($urandom_range(UNIT, 8 * UNIT));
    endfunction

    // mostly physical states: |u| at most the Lorentz factor, cs2 within [0,1]
    task automatic random_faces(int count);
        logic [LOR_W-1:0]        gl, gr;
        logic signed [VEL_W-1:0] vl, vr;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_face(CS_W'($urandom_range(0, UNIT)), VEL_W'($urandom),
                          LOR_W'($urandom_range(UNIT, 32'h7FFFFFFF)),
                          CS_W'($urandom_range(0, UNIT)), VEL_W'($urandom),
                          LOR_W'($urandom_range(UNIT, 32'h7FFFFFFF)));
            end else begin
                gl = rand_lorentz();
                gr = rand_lorentz();
                vl = VEL_W'($urandom_range(0, gl));
                vr = VEL_W'($urandom_range(0, gr));
                if ($urandom_range(0, 1)) vl = -vl;
                if ($urandom_range(0, 1)) vr = -vr;
                send_face(CS_W'($urandom_range(0, UNIT)), vl, gl,
                          CS_W'($urandom_range(0, UNIT)), vr, gr);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_mode(1'b0);

        // extremes, at rest, negative discriminant, superluminal, saturation
        send_face('0, '0, LOR_W'(UNIT), '0, '0, LOR_W'(UNIT));
        send_face(CS_W'(UNIT), '0, LOR_W'(UNIT), CS_W'(UNIT), '0, LOR_W'(UNIT));
        send_face(CS_W'(UNIT / 3), '0, LOR_W'(UNIT), CS_W'(UNIT / 3), '0, LOR_W'(UNIT));
        send_face(CS_W'(UNIT / 3), 32'sh7FFFFFFF, LOR_W'(UNIT),
                  CS_W'(UNIT / 3), '0, LOR_W'(UNIT));
        send_face(CS_W'(UNIT / 3), 32'sh80000000, LOR_W'(UNIT),
                  CS_W'(UNIT / 3), 32'sh80000000, LOR_W'(UNIT));
        send_face('0, VEL_W'(3 * UNIT), LOR_W'(UNIT), '0, -VEL_W'(3 * UNIT), LOR_W'(UNIT));
        send_face('0, VEL_W'(2 * UNIT), LOR_W'(3 * UNIT), '0, -VEL_W'(2 * UNIT),
                  LOR_W'(3 * UNIT));
        send_face(CS_W'(UNIT), 32'sh7FFFFFFF, 31'h7FFFFFFF,
                  CS_W'(UNIT), 32'sh80000000, 31'h7FFFFFFF);
        send_face('0, 32'sh7FFFFFFF, 31'h7FFFFFFF, '0, 32'sh80000000, 31'h7FFFFFFF);
        send_face(CS_W'(UNIT / 2), '0, 31'h7FFFFFFF, CS_W'(UNIT - 1), -1, LOR_W'(UNIT));
        send_face(CS_W'(1), 1, LOR_W'(UNIT + 1), CS_W'(UNIT / 4), -1, LOR_W'(2 * UNIT));
        send_face(CS_W'(UNIT / 4), VEL_W'(UNIT), LOR_W'(UNIT + UNIT / 2),
                  CS_W'(UNIT / 4), -VEL_W'(UNIT), LOR_W'(UNIT + UNIT / 2));
        random_faces(650);

        // hold off until the pipeline is empty, then switch to fixed bounds
        drain();
        write_mode(1'b1);
        send_face('0, 32'sh7FFFFFFF, 31'h7FFFFFFF, CS_W'(UNIT), 32'sh80000000, LOR_W'(UNIT));
        random_faces(150);
        drain();
        write_mode(1'b0);
        random_faces(400);

        // back to back, no idling on either side
        quiet <= 1'b1;
        random_faces(300);
        drain();
        if (errors == 0)
            $display("relativistic_wave_speed_bounds verification clean");
        else
            $display("relativistic_wave_speed_bounds verification failed");
        $finish;
    end

endmodule

FILE: relativistic_wave_speed_bounds.f
rtl/rwsb_pkg.sv
rtl/rwsb_sqrt.sv
rtl/rwsb_state.sv
rtl/rwsb_div.sv
rtl/relativistic_wave_speed_bounds.sv
tb/tb_checker.sv
tb/tb_top.sv
